// File: src/cdgc_pkg.sv
// Shared types, constants and lookup functions for the greedy change engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cdgc_pkg;

	localparam int NUM_DENOMS = 10;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = 4;
	localparam int AMT_W      = 24;
	localparam int PCS_W      = 16;
	localparam int BAL_W      = 27;
	localparam int STS_W      = 3;
	localparam int VAL_W      = 10;
	localparam int RECIP_SH   = 24;
	localparam int RECIP_W    = 25;
	localparam int PROD_W     = AMT_W + RECIP_W;
	localparam int SV_W       = COUNT_BITS + VAL_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [BAL_W-1:0]      BAL_MAX   = '1;
	// value of the reset stock: sum of reset count times denomination value
	localparam logic [BAL_W-1:0]      BAL_RESET = 27'd6843;

	typedef enum logic [STS_W-1:0] {
		ST_OK          = 3'd0,
		ST_PARTIAL     = 3'd1,
		ST_NONE        = 3'd2,
		ST_BAD_AMOUNT  = 3'd3,
		ST_BAD_DEPOSIT = 3'd4,
		ST_PIECE       = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		EM_DEPOSIT,
		EM_BAD_DEP,
		EM_BAD_AMT,
		EM_PIECE,
		EM_SUMMARY
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  dep_calc;
		logic  dep_mul;
		logic  dep_bal;
		logic  w_mul;
		logic  w_qv;
		logic  w_corr;
		logic  w_apply;
		logic  next_idx;
		logic  emit;
		emit_t kind;
	} cdgc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op;
		logic dep_ok;
		logic amt_ok;
		logic skip;
		logic idx_last;
		logic out_free;
	} cdgc_sts_t;

	// denomination value of a slot, largest first
	function automatic logic [VAL_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
		logic [VAL_W-1:0] v;
		case (idx)
			4'd0:    v = 10'd1000;
			4'd1:    v = 10'd500;
			4'd2:    v = 10'd200;
			4'd3:    v = 10'd100;
			4'd4:    v = 10'd50;
			4'd5:    v = 10'd20;
			4'd6:    v = 10'd10;
			4'd7:    v = 10'd5;
			4'd8:    v = 10'd2;
			4'd9:    v = 10'd1;
			default: v = 10'd1;
		endcase
		return v;
	endfunction

	// floor(2^24 / value); quotient estimate is low by at most one
	function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
		logic [RECIP_W-1:0] m;
		case (idx)
			4'd0:    m = 25'd16777;
			4'd1:    m = 25'd33554;
			4'd2:    m = 25'd83886;
			4'd3:    m = 25'd167772;
			4'd4:    m = 25'd335544;
			4'd5:    m = 25'd838860;
			4'd6:    m = 25'd1677721;
			4'd7:    m = 25'd3355443;
			4'd8:    m = 25'd8388608;
			4'd9:    m = 25'd16777216;
			default: m = 25'd16777216;
		endcase
		return m;
	endfunction

	// stock after reset
	function automatic logic [COUNT_BITS-1:0] reset_count(input logic [IDX_W-1:0] idx);
		logic [COUNT_BITS-1:0] c;
		case (idx)
			4'd0:    c = 16'd5;
			4'd1:    c = 16'd2;
			4'd2:    c = 16'd1;
			4'd3:    c = 16'd2;
			4'd4:    c = 16'd5;
			4'd5:    c = 16'd5;
			4'd6:    c = 16'd5;
			4'd7:    c = 16'd3;
			4'd8:    c = 16'd4;
			4'd9:    c = 16'd20;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

endpackage

// File: src/cdgc_in_if.sv
// Request channel: valid/ready handshake with one transaction item.
// Depends on cdgc_pkg for field widths.
interface cdgc_in_if import cdgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [IDX_W-1:0] slot;
	logic [AMT_W-1:0] amount;

	modport source (output valid, output op, output slot, output amount, input ready);
	modport sink   (input valid, input op, input slot, input amount, output ready);
endinterface

// File: src/cdgc_out_if.sv
// Response channel: valid/ready handshake with one result item.
// Depends on cdgc_pkg for field widths.
interface cdgc_out_if import cdgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] slot_out;
	logic [PCS_W-1:0] pieces;
	logic [AMT_W-1:0] dispensed_total;
	logic [BAL_W-1:0] balance;
	logic [STS_W-1:0] status;
	logic             last;

	modport source (output valid, output slot_out, output pieces, output dispensed_total,
		output balance, output status, output last, input ready);
	modport sink   (input valid, input slot_out, input pieces, input dispensed_total,
		input balance, input status, input last, output ready);
endinterface

// File: src/cash_dispense_greedy_change_core.sv
// Cash dispenser inventory engine: deposits and greedy change withdrawals.
// A deposit passes through check, calculate, multiply and balance states; a rejected item goes from
// check straight to its result. A withdrawal walks every denomination from the largest, skips empty or
// too-large ones, pays the others through multiply, quotient, correction, apply and emit, then emits a summary.
// One item at a time: a new request is taken only while the sequencer is idle; result stalls hold it.
// Reset (arst_n low) restores the initial stock and balance and empties the outputs.
module cash_dispense_greedy_change_core import cdgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cdgc_in_if.sink   req,
	cdgc_out_if.source rsp
);

	cdgc_cmd_t cmd;
	cdgc_sts_t sts;
	logic      item_ready;

	assign req.ready = item_ready;

	// sequencer
	cdgc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req.valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// counters, divider and result register
	cdgc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (req.op),
		.slot   (req.slot),
		.amount (req.amount),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: src/cdgc_ctrl.sv
// Sequencer for deposits and greedy withdrawals.
// Depends on cdgc_pkg; drives the datapath through cdgc_cmd_t, reads cdgc_sts_t.
module cdgc_ctrl import cdgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  cdgc_sts_t sts,
	output cdgc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DEP_CALC,
		S_DEP_MUL,
		S_DEP_BAL,
		S_W_MUL,
		S_W_QV,
		S_W_CORR,
		S_W_APPLY,
		S_W_EMIT,
		S_FINAL
	} state_t;

	state_t state_q;
	emit_t  kind_q;

	assign item_ready = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.kind     = kind_q;
		cmd.load     = (state_q == S_IDLE) && item_valid;
		cmd.dep_calc = (state_q == S_DEP_CALC);
		cmd.dep_mul  = (state_q == S_DEP_MUL);
		cmd.dep_bal  = (state_q == S_DEP_BAL);
		cmd.w_mul    = (state_q == S_W_MUL);
		cmd.w_qv     = (state_q == S_W_QV);
		cmd.w_corr   = (state_q == S_W_CORR);
		cmd.w_apply  = (state_q == S_W_APPLY);
		cmd.next_idx = ((state_q == S_W_MUL) && sts.skip && !sts.idx_last) ||
			((state_q == S_W_EMIT) && sts.out_free && !sts.idx_last);
		cmd.emit     = ((state_q == S_W_EMIT) || (state_q == S_FINAL)) && sts.out_free;
		if (state_q == S_W_EMIT) begin
			cmd.kind = EM_PIECE;
		end
	end

	// state and pending result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= EM_SUMMARY;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.op) begin
						if (sts.amt_ok) begin
							state_q <= S_W_MUL;
						end else begin
							kind_q  <= EM_BAD_AMT;
							state_q <= S_FINAL;
						end
					end else begin
						if (sts.dep_ok) begin
							state_q <= S_DEP_CALC;
						end else begin
							kind_q  <= EM_BAD_DEP;
							state_q <= S_FINAL;
						end
					end
				end
				S_DEP_CALC: state_q <= S_DEP_MUL;
				S_DEP_MUL:  state_q <= S_DEP_BAL;
				S_DEP_BAL: begin
					kind_q  <= EM_DEPOSIT;
					state_q <= S_FINAL;
				end
				S_W_MUL: begin
					if (!sts.skip) begin
						state_q <= S_W_QV;
					end else if (sts.idx_last) begin
						kind_q  <= EM_SUMMARY;
						state_q <= S_FINAL;
					end
				end
				S_W_QV:    state_q <= S_W_CORR;
				S_W_CORR:  state_q <= S_W_APPLY;
				S_W_APPLY: state_q <= S_W_EMIT;
				S_W_EMIT: begin
					if (sts.out_free) begin
						if (sts.idx_last) begin
							kind_q  <= EM_SUMMARY;
							state_q <= S_FINAL;
						end else begin
							state_q <= S_W_MUL;
						end
					end
				end
				S_FINAL: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/cdgc_dp.sv
// Datapath: stock counters, balance, reciprocal divider and result register.
// Depends on cdgc_pkg and cdgc_out_if; sequenced by cdgc_ctrl.
module cdgc_dp import cdgc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op,
	input  logic [IDX_W-1:0] slot,
	input  logic [AMT_W-1:0] amount,
	input  cdgc_cmd_t        cmd,
	output cdgc_sts_t        sts,
	cdgc_out_if.source       rsp
);

	// item and walk state
	logic                  op_q;
	logic [IDX_W-1:0]      slot_q;
	logic [AMT_W-1:0]      amt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [AMT_W-1:0]      rem_q;
	logic [AMT_W-1:0]      total_q;
	logic [BAL_W-1:0]      bal_q;
	logic [COUNT_BITS-1:0] counts_q [NUM_DENOMS];

	// divider and deposit intermediates
	logic [PROD_W-1:0]     prod_q;
	logic [SV_W-1:0]       sv_q;
	logic [AMT_W-1:0]      qe_q;
	logic [AMT_W-1:0]      qv_q;
	logic [AMT_W-1:0]      q_q;
	logic [AMT_W-1:0]      dq_q;
	logic [AMT_W-1:0]      rnew_q;
	logic [PCS_W-1:0]      take_q;
	logic [PCS_W-1:0]      added_q;
	logic [SV_W-1:0]       dv_q;

	// result register
	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_slot_q;
	logic [PCS_W-1:0]      out_pcs_q;
	logic [AMT_W-1:0]      out_total_q;
	logic [BAL_W-1:0]      out_bal_q;
	logic [STS_W-1:0]      out_sts_q;
	logic                  out_last_q;

	logic [VAL_W-1:0]      val;
	logic [AMT_W-1:0]      val_ext;
	logic [RECIP_W-1:0]    recip;
	logic [IDX_W-1:0]      rd_idx;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  out_free;
	logic [AMT_W:0]        dep_sum;
	logic [COUNT_BITS-1:0] dep_after;
	logic [PCS_W-1:0]      dep_added;
	logic [PROD_W-1:0]     prod_n;
	logic [SV_W-1:0]       sv_n;
	logic [AMT_W+VAL_W-1:0] qv_n;
	logic [AMT_W-1:0]      r_n;
	logic                  corr;
	logic [AMT_W-1:0]      adj;
	logic                  fits;
	logic [PCS_W-1:0]      take_n;
	logic [AMT_W-1:0]      d_n;
	logic [AMT_W-1:0]      rem_n;
	logic [SV_W-1:0]       dv_n;
	logic [BAL_W:0]        bal_sum;
	logic [BAL_W-1:0]      bal_dep;
	status_t               sum_sts;

	// deposits value the deposit slot, withdrawals the slot being walked
	assign val     = denom_value(op_q ? idx_q : slot_q);
	assign val_ext = {{(AMT_W-VAL_W){1'b0}}, val};
	assign recip   = denom_recip(idx_q);
	assign rd_idx  = cmd.dep_calc ? slot_q : idx_q;
	assign rd_count = counts_q[rd_idx];
	assign out_free = !out_valid_q || rsp.ready;

	// status to controller
	always_comb begin
		sts.op       = op_q;
		sts.dep_ok   = (slot_q < IDX_W'(NUM_DENOMS)) && (amt_q != '0);
		sts.amt_ok   = (amt_q != '0) && ({{(BAL_W-AMT_W){1'b0}}, amt_q} <= bal_q);
		sts.skip     = (rd_count == '0) || (rem_q < val_ext);
		sts.idx_last = (idx_q == IDX_W'(NUM_DENOMS - 1));
		sts.out_free = out_free;
	end

	// deposit: saturating add and pieces actually taken in
	always_comb begin
		dep_sum   = {{(AMT_W+1-COUNT_BITS){1'b0}}, rd_count} + {1'b0, amt_q};
		dep_after = (dep_sum > {{(AMT_W+1-COUNT_BITS){1'b0}}, COUNT_MAX}) ?
			COUNT_MAX : dep_sum[COUNT_BITS-1:0];
		dep_added = dep_after - rd_count;
		dv_n      = {{VAL_W{1'b0}}, added_q} * {{COUNT_BITS{1'b0}}, val};
		bal_sum   = {1'b0, bal_q} + {{(BAL_W+1-SV_W){1'b0}}, dv_q};
		bal_dep   = (bal_sum > {1'b0, BAL_MAX}) ? BAL_MAX : bal_sum[BAL_W-1:0];
	end

	// withdrawal: reciprocal quotient, one-step correction, clamp to stock
	always_comb begin
		prod_n = {{RECIP_W{1'b0}}, rem_q} * {{AMT_W{1'b0}}, recip};
		sv_n   = {{VAL_W{1'b0}}, rd_count} * {{COUNT_BITS{1'b0}}, val};
		qv_n   = {{VAL_W{1'b0}}, prod_q[RECIP_SH+AMT_W-1:RECIP_SH]} *
			{{AMT_W{1'b0}}, val};
		r_n    = rem_q - qv_q;
		corr   = (r_n >= val_ext);
		adj    = corr ? val_ext : '0;
		fits   = (q_q <= {{(AMT_W-COUNT_BITS){1'b0}}, rd_count});
		take_n = fits ? q_q[PCS_W-1:0] : rd_count;
		d_n    = fits ? dq_q : sv_q[AMT_W-1:0];
		rem_n  = fits ? rnew_q : (rem_q - sv_q[AMT_W-1:0]);
	end

	// summary status
	always_comb begin
		if (rem_q == '0) begin
			sum_sts = ST_OK;
		end else if (total_q != '0) begin
			sum_sts = ST_PARTIAL;
		end else begin
			sum_sts = ST_NONE;
		end
	end

	// stock and balance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q <= BAL_RESET;
			for (int i = 0; i < NUM_DENOMS; i++) begin
				counts_q[i] <= reset_count(IDX_W'(i));
			end
		end else begin
			if (cmd.dep_calc) begin
				counts_q[slot_q] <= dep_after;
			end
			if (cmd.dep_bal) begin
				bal_q <= bal_dep;
			end
			if (cmd.w_apply) begin
				counts_q[idx_q] <= rd_count - take_n;
				bal_q           <= bal_q - {{(BAL_W-AMT_W){1'b0}}, d_n};
			end
		end
	end

	// item capture and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			slot_q  <= slot;
			amt_q   <= amount;
			rem_q   <= amount;
			total_q <= '0;
			idx_q   <= '0;
		end
		if (cmd.next_idx) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.dep_calc) begin
			added_q <= dep_added;
		end
		if (cmd.dep_mul) begin
			dv_q <= dv_n;
		end
		if (cmd.w_mul) begin
			prod_q <= prod_n;
			sv_q   <= sv_n;
		end
		if (cmd.w_qv) begin
			qe_q <= prod_q[RECIP_SH+AMT_W-1:RECIP_SH];
		end
		if (cmd.w_corr) begin
			q_q    <= qe_q + {{(AMT_W-1){1'b0}}, corr};
			dq_q   <= qv_q + adj;
			rnew_q <= r_n - adj;
		end
		if (cmd.w_apply) begin
			take_q  <= take_n;
			rem_q   <= rem_n;
			total_q <= total_q + d_n;
		end
	end

	// quotient estimate times value, taken from the product with the estimate
	always_ff @(posedge clk) begin
		if (cmd.w_qv) begin
			qv_q <= qv_n[AMT_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_bal_q <= bal_q;
			case (cmd.kind)
				EM_DEPOSIT: begin
					out_slot_q  <= slot_q;
					out_pcs_q   <= added_q;
					out_total_q <= '0;
					out_sts_q   <= ST_OK;
					out_last_q  <= 1'b1;
				end
				EM_BAD_DEP: begin
					out_slot_q  <= '0;
					out_pcs_q   <= '0;
					out_total_q <= '0;
					out_sts_q   <= ST_BAD_DEPOSIT;
					out_last_q  <= 1'b1;
				end
				EM_BAD_AMT: begin
					out_slot_q  <= '0;
					out_pcs_q   <= '0;
					out_total_q <= '0;
					out_sts_q   <= ST_BAD_AMOUNT;
					out_last_q  <= 1'b1;
				end
				EM_PIECE: begin
					out_slot_q  <= idx_q;
					out_pcs_q   <= take_q;
					out_total_q <= total_q;
					out_sts_q   <= ST_PIECE;
					out_last_q  <= 1'b0;
				end
				EM_SUMMARY: begin
					out_slot_q  <= '0;
					out_pcs_q   <= '0;
					out_total_q <= total_q;
					out_sts_q   <= sum_sts;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_slot_q  <= '0;
					out_pcs_q   <= '0;
					out_total_q <= '0;
					out_sts_q   <= ST_NONE;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.slot_out        = out_slot_q;
	assign rsp.pieces          = out_pcs_q;
	assign rsp.dispensed_total = out_total_q;
	assign rsp.balance         = out_bal_q;
	assign rsp.status          = out_sts_q;
	assign rsp.last            = out_last_q;

	// corrected remainder is below the denomination value
	a_rem_below_val: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w_corr |=> (rnew_q < val_ext))
		else $error("corrected remainder not below denomination value");

	// paid plus outstanding always equals the requested amount
	a_total_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q && cmd.w_apply) |=>
		(({1'b0, total_q} + {1'b0, rem_q}) == {1'b0, amt_q}))
		else $error("withdrawal total and remainder out of step");

	// every denomination that is paid out hands out at least one piece
	a_take_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w_apply |-> (take_n != '0))
		else $error("piece line with zero pieces");

	// a result is only loaded when the result register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten");

endmodule

// File: sim/cdgc_payout_check.sv
// Scoreboard for the greedy change engine: tracks the cash stock, predicts every result
// item and compares it with what the block hands out.
// Depends on cdgc_pkg and the cdgc_in_if / cdgc_out_if channel interfaces.
package cdgc_tb_pkg;
	localparam logic OP_DEPOSIT  = 1'b0;
	localparam logic OP_WITHDRAW = 1'b1;
endpackage

module cdgc_payout_check import cdgc_pkg::*; import cdgc_tb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cdgc_in_if                 req,
	cdgc_out_if                rsp,
	output int unsigned        fail_count,
	output int unsigned        owed_count,
	output logic [BAL_W-1:0]   cash_hint
);

	typedef struct {
		logic [IDX_W-1:0] slot_out;
		logic [PCS_W-1:0] pieces;
		logic [AMT_W-1:0] total;
		logic [BAL_W-1:0] balance;
		status_t          status;
		logic             last;
	} payout_t;

	// face values, largest first, and the stock loaded at reset
	localparam int unsigned FACE [NUM_DENOMS] = '{1000, 500, 200, 100, 50, 20, 10, 5, 2, 1};
	localparam int unsigned START_STOCK [NUM_DENOMS] = '{5, 2, 1, 2, 5, 5, 5, 3, 4, 20};

	logic [COUNT_BITS-1:0] stock [NUM_DENOMS];
	logic [BAL_W-1:0]      cash;
	payout_t               owed_lines [$];
	int unsigned           errs;

	// value of the whole stock, saturated to the balance width
	function automatic logic [BAL_W-1:0] stock_value();
		longint unsigned sum;
		sum = 0;
		for (int i = 0; i < NUM_DENOMS; i++)
			sum += longint'(stock[i]) * FACE[i];
		return (sum > BAL_MAX) ? BAL_MAX : sum[BAL_W-1:0];
	endfunction

	task automatic owe_line(input longint unsigned slot, input longint unsigned pcs,
		input longint unsigned total, input status_t status, input logic last);
		payout_t line;
		line.slot_out = slot[IDX_W-1:0];
		line.pieces   = pcs[PCS_W-1:0];
		line.total    = total[AMT_W-1:0];
		line.balance  = cash;
		line.status   = status;
		line.last     = last;
		owed_lines.push_back(line);
	endtask

	// apply one accepted item to the stock and queue the result items it owes
	task automatic predict_payout(input logic op, input logic [IDX_W-1:0] slot,
		input logic [AMT_W-1:0] amount);
		longint unsigned filled;
		longint unsigned added;
		longint unsigned remaining;
		longint unsigned paid;
		longint unsigned take;
		status_t         outcome;
		if (op == OP_DEPOSIT) begin
			if (slot >= NUM_DENOMS || amount == 0) begin
				owe_line(0, 0, 0, ST_BAD_DEPOSIT, 1'b1);
			end else begin
				filled = longint'(stock[slot]) + amount;
				if (filled > COUNT_MAX)
					filled = COUNT_MAX;
				added = filled - stock[slot];
				stock[slot] = filled[COUNT_BITS-1:0];
				cash = stock_value();
				owe_line(slot, added, 0, ST_OK, 1'b1);
			end
		end else if (amount == 0 || amount > cash) begin
			owe_line(0, 0, 0, ST_BAD_AMOUNT, 1'b1);
		end else begin
			// greedy walk from the largest face value down
			remaining = amount;
			paid = 0;
			for (int i = 0; i < NUM_DENOMS; i++) begin
				if (stock[i] == 0)
					continue;
				take = remaining / FACE[i];
				if (take == 0)
					continue;
				if (take > stock[i])
					take = stock[i];
				stock[i] = stock[i] - take[COUNT_BITS-1:0];
				remaining -= take * FACE[i];
				paid += take * FACE[i];
				cash = stock_value();
				owe_line(i, take, paid, ST_PIECE, 1'b0);
			end
			if (remaining == 0)
				outcome = ST_OK;
			else if (paid > 0)
				outcome = ST_PARTIAL;
			else
				outcome = ST_NONE;
			owe_line(0, 0, paid, outcome, 1'b1);
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	// watch both channels; the request side is handled first
	always @(posedge clk or negedge arst_n) begin : watch
		payout_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOMS; i++)
				stock[i] = COUNT_BITS'(START_STOCK[i]);
			cash = stock_value();
			owed_lines.delete();
			errs = 0;
		end else begin
			if (req.valid && req.ready)
				predict_payout(req.op, req.slot, req.amount);
			if (rsp.valid && rsp.ready) begin
				if (owed_lines.size() == 0) begin
					$error("result item with none pending: status %0d", rsp.status);
					errs++;
				end else begin
					want = owed_lines.pop_front();
					check_field("slot_out", want.slot_out, rsp.slot_out);
					check_field("pieces", want.pieces, rsp.pieces);
					check_field("dispensed_total", want.total, rsp.dispensed_total);
					check_field("balance", want.balance, rsp.balance);
					check_field("status", want.status, rsp.status);
					check_field("last", want.last, rsp.last);
				end
			end
		end
		fail_count <= errs;
		owed_count <= owed_lines.size();
		cash_hint  <= cash;
	end

endmodule

// File: sim/tb_top.sv
// Top of the greedy change engine testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on cdgc_pkg, cdgc_tb_pkg, the channel interfaces, the core and cdgc_payout_check.
module tb_top;
	import cdgc_pkg::*;
	import cdgc_tb_pkg::*;

	localparam int RANDOM_ITEMS = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [AMT_W-1:0] AMT_TOP = '1;

	logic clk = 1'b0;
	logic arst_n;

	int unsigned      fail_count;
	int unsigned      owed_count;
	logic [BAL_W-1:0] cash_hint;
	int unsigned      send_idle_pct;
	int unsigned      recv_stall_pct;
	int unsigned      quiet_cycles;

	cdgc_in_if  req_ch ();
	cdgc_out_if rsp_ch ();

	cash_dispense_greedy_change_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cdgc_payout_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.owed_count (owed_count),
		.cash_hint  (cash_hint)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// present one item and hold it until the block takes it
	task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
		input logic [AMT_W-1:0] amount);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.op     <= op;
		req_ch.slot   <= slot;
		req_ch.amount <= amount;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// mostly well-formed deposits and withdrawals sized to the current balance
	task automatic send_random();
		logic [AMT_W-1:0] cap;
		logic [IDX_W-1:0] slot;
		logic [AMT_W-1:0] amount;
		int unsigned      pick;
		int unsigned      mode;
		cap = (cash_hint > AMT_TOP) ? AMT_TOP : cash_hint[AMT_W-1:0];
		pick = $urandom_range(0, 99);
		slot = IDX_W'($urandom_range(0, NUM_DENOMS - 1));
		mode = $urandom_range(0, 99);
		if (pick < 40 || cap == 0) begin
			if (mode < 75)
				amount = AMT_W'($urandom_range(1, 50));
			else if (mode < 93)
				amount = AMT_W'($urandom_range(1, 5000));
			else if (mode < 95)
				amount = AMT_W'($urandom_range(1, AMT_TOP));
			else if (mode < 98)
				slot = IDX_W'($urandom_range(NUM_DENOMS, 15));
			else
				amount = 0;
			if (mode >= 95 && mode < 98)
				amount = AMT_W'($urandom_range(0, AMT_TOP));
			send_item(OP_DEPOSIT, slot, amount);
		end else begin
			slot = IDX_W'($urandom_range(0, 15));
			if (mode < 45)
				amount = AMT_W'($urandom_range(1, (cap < 2000) ? cap : 2000));
			else if (mode < 80)
				amount = AMT_W'($urandom_range(1, cap));
			else if (mode < 90)
				amount = cap;
			else if (mode < 95 && cash_hint < AMT_TOP)
				amount = AMT_W'($urandom_range(cash_hint + 1, AMT_TOP));
			else
				amount = 0;
			send_item(OP_WITHDRAW, slot, amount);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		req_ch.valid  <= 1'b0;
		req_ch.op     <= OP_DEPOSIT;
		req_ch.slot   <= '0;
		req_ch.amount <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad amounts, a full ten-line payout, emptying the stock
		send_item(OP_WITHDRAW, 4'd0, 24'd0);
		send_item(OP_WITHDRAW, 4'd0, 24'd6844);
		send_item(OP_WITHDRAW, 4'd15, AMT_TOP);
		send_item(OP_WITHDRAW, 4'd0, 24'd1888);
		send_item(OP_WITHDRAW, 4'd0, 24'd4955);
		send_item(OP_WITHDRAW, 4'd0, 24'd1);
		// nothing small enough to pay, then only part payable
		send_item(OP_DEPOSIT, 4'd0, 24'd1);
		send_item(OP_WITHDRAW, 4'd0, 24'd1);
		send_item(OP_DEPOSIT, 4'd1, 24'd1);
		send_item(OP_WITHDRAW, 4'd0, 24'd1200);
		// count saturation and rejected deposits
		send_item(OP_DEPOSIT, 4'd9, AMT_TOP);
		send_item(OP_DEPOSIT, 4'd9, 24'd5);
		send_item(OP_DEPOSIT, 4'd10, 24'd3);
		send_item(OP_DEPOSIT, 4'd15, 24'd7);
		send_item(OP_DEPOSIT, 4'd4, 24'd0);
		send_item(OP_WITHDRAW, 4'd0, 24'd66035);
		// large balance so that the top amount bits are payable
		send_item(OP_DEPOSIT, 4'd0, AMT_TOP);
		send_item(OP_WITHDRAW, 4'd0, AMT_TOP);
		send_item(OP_WITHDRAW, 4'd0, 24'h800000);
		for (int s = 1; s < NUM_DENOMS; s++)
			send_item(OP_DEPOSIT, IDX_W'(s), AMT_W'($urandom_range(1, 30)));

		// random items across the idle and stall phases
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 19 : 0;
			recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 19 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 4 + 1; n++)
				send_random();
		end
		req_ch.valid <= 1'b0;
		recv_stall_pct = 0;

		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && owed_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
